### hdl/scsd_pkg.sv
// scsd_pkg: shared types and constants of the scanline crosswalk stripe detector
// segment class codes, level register indexes and reset values
// no dependencies
package scsd_pkg;

   localparam int unsigned PIXEL_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [1:0] class_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam class_type CLASS_NONE = 2'd0;
   localparam class_type CLASS_DARK = 2'd1;
   localparam class_type CLASS_MID = 2'd2;
   localparam class_type CLASS_LIGHT = 2'd3;

   localparam csr_index_type CSR_DARK_LEVEL = 2'd0;
   localparam csr_index_type CSR_MID_LEVEL = 2'd1;
   localparam csr_index_type CSR_LIGHT_LEVEL = 2'd2;

   localparam pixel_type DARK_LEVEL_RESET = 8'd0;
   localparam pixel_type MID_LEVEL_RESET = 8'd128;
   localparam pixel_type LIGHT_LEVEL_RESET = 8'd255;

   typedef struct packed {
      pixel_type dark;
      pixel_type mid;
      pixel_type light;
   } levels_type;

   // one closed run that carries a class
   typedef struct packed {
      logic valid;
      class_type cls;
   } segment_type;

endpackage

### hdl/scsd_req_if.sv
// scsd_req_if: request channel of the stripe detector, one pixel per request
// depends on scsd_pkg
interface scsd_req_if;
   logic valid;
   logic ready;
   scsd_pkg::pixel_type pixel;
   logic row_end;

   modport source (output valid, output pixel, output row_end, input ready);
   modport sink (input valid, input pixel, input row_end, output ready);
endinterface

// scsd_rsp_if: response channel, one flag per row
interface scsd_rsp_if;
   logic valid;
   logic ready;
   logic crossing_found;

   modport source (output valid, output crossing_found, input ready);
   modport sink (input valid, input crossing_found, output ready);
endinterface

### hdl/scsd_classify.sv
// scsd_classify: maps a run value to its segment class, priority dark, mid, light
// depends on scsd_pkg
module scsd_classify (
   input scsd_pkg::pixel_type value,
   input scsd_pkg::levels_type levels,
   output scsd_pkg::class_type cls
);
   import scsd_pkg::*;

   always_comb begin
      if (value == levels.dark) begin
         cls = CLASS_DARK;
      end else if (value == levels.mid) begin
         cls = CLASS_MID;
      end else if (value == levels.light) begin
         cls = CLASS_LIGHT;
      end else begin
         cls = CLASS_NONE;
      end
   end

endmodule

### hdl/scsd_matcher.sv
// scsd_matcher: advances the dark/light alternation match by up to two segments
// depends on scsd_pkg
module scsd_matcher #(
   parameter int unsigned PATTERN_LENGTH = 13
) (
   input logic [$clog2(PATTERN_LENGTH+1)-1:0] match_cur,
   input logic found_cur,
   input scsd_pkg::segment_type seg_first,
   input scsd_pkg::segment_type seg_second,
   output logic [$clog2(PATTERN_LENGTH+1)-1:0] match_next,
   output logic found_next
);
   import scsd_pkg::*;

   localparam int unsigned MATCH_W = $clog2(PATTERN_LENGTH + 1);
   localparam logic [MATCH_W-1:0] FULL_LEN = MATCH_W'(PATTERN_LENGTH);
   localparam logic [MATCH_W-1:0] BORDER_LEN = MATCH_W'(PATTERN_LENGTH - 2);

   // returns {found, match length}
   function automatic logic [MATCH_W:0] feed(input logic [MATCH_W:0] cur,
                                              input segment_type seg);
      logic [MATCH_W-1:0] len;
      logic hit;
      class_type expected;
      len = cur[MATCH_W-1:0];
      hit = cur[MATCH_W];
      expected = len[0] ? CLASS_LIGHT : CLASS_DARK;
      if (seg.valid) begin
         if (seg.cls == expected) begin
            len = len + MATCH_W'(1);
         end else begin
            // restart: a dark segment opens a new match
            len = (seg.cls == CLASS_DARK) ? MATCH_W'(1) : '0;
         end
         if (len == FULL_LEN) begin
            hit = 1'b1;
            len = BORDER_LEN;
         end
      end
      return {hit, len};
   endfunction

   logic [MATCH_W:0] after_first;
   logic [MATCH_W:0] after_second;

   always_comb begin
      after_first = feed({found_cur, match_cur}, seg_first);
      after_second = feed(after_first, seg_second);
   end

   assign match_next = after_second[MATCH_W-1:0];
   assign found_next = after_second[MATCH_W];

endmodule

### hdl/scanline_crosswalk_stripe_detector_core.sv
// scanline_crosswalk_stripe_detector_core: top level of the stripe detector
// depends on scsd_pkg, scsd_req_if, scsd_rsp_if, scsd_classify, scsd_matcher
//
// Usage: pixels of one image row arrive on req_bus, one request each, with
// row_end high on the last pixel. Runs of equal pixels matching the dark,
// mid or light level become segments; rsp_bus carries one crossing_found
// flag per row, high when the row held PATTERN_LENGTH alternating dark and
// light segments starting and ending dark. Levels are set through the csr_
// write port while no row is in flight.
// Response path: a row_end request is accepted into the input register and
// processed once the response register is free; its response is registered.
// Throughput: one pixel per cycle outside a row_end stall; the input register,
// the run/match state and the response register each take one step per clock.
// Stall: while a response waits unaccepted, pixels without row_end keep
// flowing; a second row_end holds in the input register until the waiting
// response is taken.
// Reset: synchronous; clears both channel registers, the run/match state
// and restores the default levels.
module scanline_crosswalk_stripe_detector_core #(
   parameter int unsigned PATTERN_LENGTH = 13
) (
   input logic clock,
   input logic reset,
   scsd_req_if.sink req_bus,
   scsd_rsp_if.source rsp_bus,
   input logic csr_write_enable,
   input scsd_pkg::csr_index_type csr_index,
   input scsd_pkg::pixel_type csr_write_data
);
   import scsd_pkg::*;

   localparam int unsigned MATCH_W = $clog2(PATTERN_LENGTH + 1);

   levels_type levels_ff, levels_in;

   logic s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff, s1_pixel_in;
   logic s1_last_ff, s1_last_in;

   pixel_type run_value_ff, run_value_in;
   logic run_active_ff, run_active_in;
   logic [MATCH_W-1:0] match_ff, match_in;
   logic found_ff, found_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;

   logic out_free;
   logic s1_fire;
   logic req_take;
   logic new_run;
   pixel_type run_value_after;
   class_type cls_old;
   class_type cls_after;
   segment_type seg_first;
   segment_type seg_second;
   logic [MATCH_W-1:0] match_step;
   logic found_step;

   // level registers
   always_comb begin
      levels_in = levels_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DARK_LEVEL: levels_in.dark = csr_write_data;
            CSR_MID_LEVEL: levels_in.mid = csr_write_data;
            CSR_LIGHT_LEVEL: levels_in.light = csr_write_data;
            default: levels_in = levels_ff;
         endcase
      end
   end

   // handshake
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_last_in = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_bus.pixel;
         s1_last_in = req_bus.row_end;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // run segmentation
   assign new_run = !(run_active_ff && (s1_pixel_ff == run_value_ff));
   assign run_value_after = new_run ? s1_pixel_ff : run_value_ff;

   scsd_classify u_class_old (
      .value(run_value_ff),
      .levels(levels_ff),
      .cls(cls_old)
   );

   scsd_classify u_class_after (
      .value(run_value_after),
      .levels(levels_ff),
      .cls(cls_after)
   );

   // old run closes when a new one opens; at row end the open run closes too
   always_comb begin
      seg_first.valid = new_run && run_active_ff && (cls_old != CLASS_NONE);
      seg_first.cls = cls_old;
      seg_second.valid = s1_last_ff && (cls_after != CLASS_NONE);
      seg_second.cls = cls_after;
   end

   scsd_matcher #(
      .PATTERN_LENGTH(PATTERN_LENGTH)
   ) u_matcher (
      .match_cur(match_ff),
      .found_cur(found_ff),
      .seg_first(seg_first),
      .seg_second(seg_second),
      .match_next(match_step),
      .found_next(found_step)
   );

   always_comb begin
      run_value_in = run_value_ff;
      run_active_in = run_active_ff;
      match_in = match_ff;
      found_in = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in = rsp_found_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            run_value_in = '0;
            run_active_in = 1'b0;
            match_in = '0;
            found_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_found_in = found_step;
         end else begin
            run_value_in = run_value_after;
            run_active_in = 1'b1;
            match_in = match_step;
            found_in = found_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '{dark: DARK_LEVEL_RESET, mid: MID_LEVEL_RESET,
                        light: LIGHT_LEVEL_RESET};
         s1_valid_ff <= 1'b0;
         run_value_ff <= '0;
         run_active_ff <= 1'b0;
         match_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         levels_ff <= levels_in;
         s1_valid_ff <= s1_valid_in;
         run_value_ff <= run_value_in;
         run_active_ff <= run_active_in;
         match_ff <= match_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s1_pixel_in;
      s1_last_ff <= s1_last_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.crossing_found = rsp_found_ff;

endmodule

### hdl/scsd_checker.sv
// scsd_checker: port-level assertions for the stripe detector
// bound to scanline_crosswalk_stripe_detector_core; depends on nothing else
module scsd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_row_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_crossing_found
);

   // no response is pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a fresh response must trace back to an accepted row_end request
   a_rsp_from_row_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_row_end, 2))
      else $error("response without a row_end request");

   // a stalled response holds its flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crossing_found))
      else $error("stalled response changed");

endmodule

bind scanline_crosswalk_stripe_detector_core scsd_checker u_scsd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .req_row_end(req_bus.row_end),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_crossing_found(rsp_bus.crossing_found)
);
